// ----- hdl/dcws_pkg.sv -----
package dcws_pkg;

   localparam int FREQ_W         = 24;
   localparam int SHAPE_W        = 2;
   localparam int TUNE_W         = 24;
   localparam int TUNE_FRAC_BITS = 20;
   localparam int STEP_W         = 28;
   localparam int HALF_W         = 14;
   localparam int WORD_W         = 16;
   localparam int IDX_W          = 3;
   localparam int PROD_W         = FREQ_W + TUNE_W;
   localparam int CSR_DATA_W     = 32;
   localparam int CSR_ADDR_W     = 3;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

   localparam logic [FREQ_W-1:0] FREQ_LIMIT_RESET = 24'd12000000;
   localparam logic [TUNE_W-1:0] TUNING_RESET     = 24'd11251220;

   localparam logic [0:0] CSR_FREQ_LIMIT = 1'b0;
   localparam logic [0:0] CSR_TUNING     = 1'b1;

   localparam logic [SHAPE_W-1:0] SHAPE_CODE_SINE     = 2'd0;
   localparam logic [SHAPE_W-1:0] SHAPE_CODE_TRIANGLE = 2'd1;
   localparam logic [SHAPE_W-1:0] SHAPE_CODE_SQUARE   = 2'd2;

   typedef enum logic [1:0] {
      SHAPE_SINE,
      SHAPE_TRIANGLE,
      SHAPE_SQUARE
   } shape_type;

   typedef logic [IDX_W-1:0] word_idx_type;

   localparam word_idx_type IDX_CTRL_RESET = 3'd0;
   localparam word_idx_type IDX_FREQ0_LO   = 3'd1;
   localparam word_idx_type IDX_FREQ0_HI   = 3'd2;
   localparam word_idx_type IDX_FREQ1_LO   = 3'd3;
   localparam word_idx_type IDX_FREQ1_HI   = 3'd4;
   localparam word_idx_type IDX_PHASE0     = 3'd5;
   localparam word_idx_type IDX_PHASE1     = 3'd6;
   localparam word_idx_type IDX_CTRL_RUN   = 3'd7;

   localparam logic [WORD_W-1:0] PREFIX_FREQ0 = 16'h4000;
   localparam logic [WORD_W-1:0] PREFIX_FREQ1 = 16'h8000;
   localparam logic [WORD_W-1:0] WORD_PHASE0  = 16'hC000;
   localparam logic [WORD_W-1:0] WORD_PHASE1  = 16'hE000;
   localparam logic [WORD_W-1:0] CTRL_BASE    = 16'h2008;
   localparam logic [WORD_W-1:0] CTRL_RESET   = 16'h0100;
   localparam logic [WORD_W-1:0] CTRL_TRI     = 16'h0002;
   localparam logic [WORD_W-1:0] CTRL_SQR     = 16'h0020;

   typedef struct packed {
      logic [STEP_W-1:0] step;
      shape_type         shape;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [WORD_W-1:0] ctrl_word(shape_type shape, logic with_reset);
      logic [WORD_W-1:0] word;
      word = CTRL_BASE;
      unique case (shape)
         SHAPE_TRIANGLE: word = word | CTRL_TRI;
         SHAPE_SQUARE:   word = word | CTRL_SQR;
         default:        word = CTRL_BASE;
      endcase
      if (with_reset) begin
         word = word | CTRL_RESET;
      end
      return word;
   endfunction

endpackage

// ----- hdl/dcws_if.sv -----
interface dcws_req_if;
   logic                          valid;
   logic                          ready;
   logic [dcws_pkg::FREQ_W-1:0]   freq;
   logic [dcws_pkg::SHAPE_W-1:0]  shape;

   modport source (output valid, freq, shape, input ready);
   modport sink   (input valid, freq, shape, output ready);
endinterface

interface dcws_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [dcws_pkg::WORD_W-1:0]   cmd_word;
   logic [dcws_pkg::IDX_W-1:0]    word_index;
   logic                          last;

   modport source (output valid, cmd_word, word_index, last, input ready);
   modport sink   (input valid, cmd_word, word_index, last, output ready);
endinterface

// ----- hdl/dcws_front.sv -----
module dcws_front (
   input  logic                          clock,
   input  logic                          reset,
   dcws_req_if.sink                      req_ch,
   input  logic [dcws_pkg::FREQ_W-1:0]   freq_limit,
   input  logic [dcws_pkg::TUNE_W-1:0]   tuning_factor,
   output dcws_pkg::push_type            push_out,
   input  logic                          push_ready
);

   logic                          a_valid_ff, a_valid_in;
   logic [dcws_pkg::FREQ_W-1:0]   a_freq_ff, a_freq_in;
   dcws_pkg::shape_type           a_shape_ff, a_shape_in;
   logic                          b_valid_ff, b_valid_in;
   dcws_pkg::item_type            b_item_ff, b_item_in;
   logic [dcws_pkg::PROD_W-1:0]   prod;
   logic                          a_adv, b_adv;

   assign b_adv        = !b_valid_ff || push_ready;
   assign a_adv        = !a_valid_ff || b_adv;
   assign req_ch.ready = a_adv;

   // clamp and shape classification
   always_comb begin
      a_freq_in = (req_ch.freq > freq_limit) ? freq_limit : req_ch.freq;
      unique case (req_ch.shape)
         dcws_pkg::SHAPE_CODE_TRIANGLE: a_shape_in = dcws_pkg::SHAPE_TRIANGLE;
         dcws_pkg::SHAPE_CODE_SQUARE:   a_shape_in = dcws_pkg::SHAPE_SQUARE;
         default:                       a_shape_in = dcws_pkg::SHAPE_SINE;
      endcase
      a_valid_in = a_adv ? req_ch.valid : a_valid_ff;
   end

   // tuning multiply
   always_comb begin
      prod            = dcws_pkg::PROD_W'(a_freq_ff) * dcws_pkg::PROD_W'(tuning_factor);
      b_item_in.step  = dcws_pkg::STEP_W'(prod >> dcws_pkg::TUNE_FRAC_BITS);
      b_item_in.shape = a_shape_ff;
      b_valid_in      = b_adv ? a_valid_ff : b_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv && req_ch.valid) begin
         a_freq_ff  <= a_freq_in;
         a_shape_ff <= a_shape_in;
      end
      if (b_adv && a_valid_ff) begin
         b_item_ff <= b_item_in;
      end
   end

   assign push_out.valid = b_valid_ff;
   assign push_out.item  = b_item_ff;

endmodule

// ----- hdl/dcws_queue.sv -----
module dcws_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  dcws_pkg::push_type         push_in,
   output dcws_pkg::push_type         pop_out,
   input  logic                       pop_take,
   output dcws_pkg::queue_status_type status
);

   dcws_pkg::item_type               entries_ff [dcws_pkg::QUEUE_DEPTH];
   logic [dcws_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [dcws_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [dcws_pkg::QPTR_W:0]        count_ff, count_in;
   logic                             push, pop;

   assign status.full  = (count_ff == (dcws_pkg::QPTR_W+1)'(dcws_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign push         = push_in.valid && !status.full;
   assign pop          = pop_take && !status.empty;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_in.item;
      end
   end

   assign pop_out.valid = !status.empty;
   assign pop_out.item  = entries_ff[rd_ptr_ff];

endmodule

// ----- hdl/dcws_back.sv -----
module dcws_back (
   input  logic                clock,
   input  logic                reset,
   input  dcws_pkg::push_type  pop_in,
   output logic                pop_take,
   dcws_rsp_if.source          rsp_ch
);

   logic                          cur_valid_ff, cur_valid_in;
   dcws_pkg::item_type            cur_item_ff;
   dcws_pkg::word_idx_type        idx_ff, idx_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [dcws_pkg::WORD_W-1:0]   rsp_word_ff, word;
   dcws_pkg::word_idx_type        rsp_idx_ff;
   logic                          rsp_last_ff;
   logic                          out_load, at_end;
   logic [dcws_pkg::HALF_W-1:0]   lo, hi;

   assign out_load = cur_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign at_end   = (idx_ff == dcws_pkg::IDX_CTRL_RUN);
   assign pop_take = pop_in.valid && (!cur_valid_ff || (out_load && at_end));
   assign lo       = cur_item_ff.step[dcws_pkg::HALF_W-1:0];
   assign hi       = cur_item_ff.step[dcws_pkg::STEP_W-1:dcws_pkg::HALF_W];

   always_comb begin
      unique case (idx_ff)
         dcws_pkg::IDX_CTRL_RESET: word = dcws_pkg::ctrl_word(cur_item_ff.shape, 1'b1);
         dcws_pkg::IDX_FREQ0_LO:   word = dcws_pkg::PREFIX_FREQ0 | dcws_pkg::WORD_W'(lo);
         dcws_pkg::IDX_FREQ0_HI:   word = dcws_pkg::PREFIX_FREQ0 | dcws_pkg::WORD_W'(hi);
         dcws_pkg::IDX_FREQ1_LO:   word = dcws_pkg::PREFIX_FREQ1 | dcws_pkg::WORD_W'(lo);
         dcws_pkg::IDX_FREQ1_HI:   word = dcws_pkg::PREFIX_FREQ1 | dcws_pkg::WORD_W'(hi);
         dcws_pkg::IDX_PHASE0:     word = dcws_pkg::WORD_PHASE0;
         dcws_pkg::IDX_PHASE1:     word = dcws_pkg::WORD_PHASE1;
         dcws_pkg::IDX_CTRL_RUN:   word = dcws_pkg::ctrl_word(cur_item_ff.shape, 1'b0);
      endcase
   end

   always_comb begin
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (pop_take) begin
         cur_valid_in = 1'b1;
         idx_in       = dcws_pkg::IDX_CTRL_RESET;
      end else if (out_load) begin
         cur_valid_in = !at_end;
         idx_in       = idx_ff + 1'b1;
      end
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= dcws_pkg::IDX_CTRL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_take) begin
         cur_item_ff <= pop_in.item;
      end
      if (out_load) begin
         rsp_word_ff <= word;
         rsp_idx_ff  <= idx_ff;
         rsp_last_ff <= at_end;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.cmd_word   = rsp_word_ff;
   assign rsp_ch.word_index = rsp_idx_ff;
   assign rsp_ch.last       = rsp_last_ff;

endmodule

// ----- hdl/dds_command_word_sequencer.sv -----
// channel   role    handshake         payload
// req_ch    sink    valid / ready     freq[23:0], shape[1:0]
// rsp_ch    source  valid / ready     cmd_word[15:0], word_index[2:0], last
// csr_*     apb     psel / penable    freq_limit (0x0), tuning_factor (0x4)
//
// each request yields eight words, one per cycle while rsp_ch is not stalled;
// a request runs through front, queue, sequencer and output register in turn
// the front clamp and multiply stages feed a two-entry queue, so up to four
// requests are taken ahead while the sequencer works; a stalled rsp_ch holds
// the output register, which backs up the queue and front until req_ch.ready drops
// synchronous reset restores freq_limit and tuning_factor and empties all stages
module dds_command_word_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   dcws_req_if.sink                          req_ch,
   dcws_rsp_if.source                        rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [dcws_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [dcws_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [dcws_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   logic [dcws_pkg::FREQ_W-1:0]   freq_limit_ff;
   logic [dcws_pkg::TUNE_W-1:0]   tuning_ff;
   logic                          csr_write;
   logic [0:0]                    csr_index;
   dcws_pkg::push_type            push, pop;
   logic                          pop_take;
   dcws_pkg::queue_status_type    q_status;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_limit_ff <= dcws_pkg::FREQ_LIMIT_RESET;
         tuning_ff     <= dcws_pkg::TUNING_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            dcws_pkg::CSR_FREQ_LIMIT: freq_limit_ff <= csr_pwdata[dcws_pkg::FREQ_W-1:0];
            dcws_pkg::CSR_TUNING:     tuning_ff     <= csr_pwdata[dcws_pkg::TUNE_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         dcws_pkg::CSR_FREQ_LIMIT: csr_prdata = dcws_pkg::CSR_DATA_W'(freq_limit_ff);
         dcws_pkg::CSR_TUNING:     csr_prdata = dcws_pkg::CSR_DATA_W'(tuning_ff);
      endcase
   end

   dcws_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .freq_limit    (freq_limit_ff),
      .tuning_factor (tuning_ff),
      .push_out      (push),
      .push_ready    (!q_status.full)
   );

   dcws_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_in  (push),
      .pop_out  (pop),
      .pop_take (pop_take),
      .status   (q_status)
   );

   dcws_back u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_in   (pop),
      .pop_take (pop_take),
      .rsp_ch   (rsp_ch)
   );

   // a word other than the last is always followed by the next word
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready && !rsp_ch.last |=>
         rsp_ch.valid && (rsp_ch.word_index == dcws_pkg::IDX_W'($past(rsp_ch.word_index) + 1'b1)))
      else $error("word sequence broken");

   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.last == (rsp_ch.word_index == dcws_pkg::IDX_CTRL_RUN)))
      else $error("last flag off the final word");

   // a stalled transfer keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=>
         rsp_ch.valid && $stable(rsp_ch.cmd_word) && $stable(rsp_ch.word_index)
         && $stable(rsp_ch.last))
      else $error("stalled transfer changed");

   assert property (@(posedge clock) disable iff (reset)
      push.valid && q_status.full |=> $stable(push.item))
      else $error("front changed an item held by a full queue");

endmodule
